>>> hdl/lrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the ranged LCG random number block.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [DATA_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [DATA_W-1:0] LCG_ADD = 32'd1013904223;

   localparam logic [DATA_W-1:0] RANGE_MIN_RST = 32'd0;
   localparam logic [DATA_W-1:0] RANGE_MAX_RST = 32'd255;

   // register index, taken from paddr[2]
   localparam logic REG_RANGE_MIN = 1'b0;
   localparam logic REG_RANGE_MAX = 1'b1;

   // item kinds
   localparam logic KIND_DRAW = 1'b0;
   localparam logic KIND_SEED = 1'b1;

   // queue between front and back
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   // bit-serial remainder unit
   localparam int unsigned DIV_STEPS = DATA_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } bk_state_type;

endpackage

>>> hdl/lcg_ranged_random_top.sv
`timescale 1ns / 1ps
// Path: a draw is queued on its push beat; the back pops it, runs 32 remainder steps
//   (none for an empty range) and loads the result register once the rsp slot is free.
// The remainder unit takes one draw at a time; seed loads only rewrite the
//   state, and a queued draw lets the front run ahead.
// Reset: range_min 0, range_max 255, generator state 0, queue and result empty.
// ----------------------------------------------------------------------------
// lcg_ranged_random_top
// 32-bit LCG with draws mapped into a configurable inclusive range.
// ----------------------------------------------------------------------------
module lcg_ranged_random_top
   import lrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_kind,
   input  logic [DATA_W-1:0]     req_seed_value,
   output logic                  empty,
   input  logic                  pop,
   output logic [DATA_W-1:0]     rsp_value,
   output logic                  rsp_range_error,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   q_status_type      q_status;
   logic              q_push, q_pop;
   logic [DATA_W-1:0] q_wdata, q_rdata;
   logic [DATA_W-1:0] range_min, range_max;

   lrr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_seed_value (req_seed_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_wdata        (q_wdata),
      .range_min      (range_min),
      .range_max      (range_max)
   );

   lrr_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   lrr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .range_min       (range_min),
      .range_max       (range_max),
      .empty           (empty),
      .pop             (pop),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule

>>> hdl/lrr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_fifo
// Short queue carrying advanced generator states from front to back.
// ----------------------------------------------------------------------------
module lrr_fifo
   import lrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic [DATA_W-1:0] rdata,
   output q_status_type      status
);

   logic [DATA_W-1:0]  mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count above depth");

endmodule

>>> hdl/lrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_front
// Accepts beats, holds range registers and generator state, advances the
// state on a draw and queues it; seed loads only rewrite the state.
// ----------------------------------------------------------------------------
module lrr_front
   import lrr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  logic                  req_kind,
   input  logic [DATA_W-1:0]     req_seed_value,
   // csr port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready,
   // queue side
   input  q_status_type          q_status,
   output logic                  q_push,
   output logic [DATA_W-1:0]     q_wdata,
   // live range
   output logic [DATA_W-1:0]     range_min,
   output logic [DATA_W-1:0]     range_max
);

   logic [DATA_W-1:0] lcg_ff, lcg_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] max_ff, max_in;
   logic [DATA_W-1:0] lcg_next;
   logic              accept, csr_wr;

   assign pready    = 1'b1;
   assign full      = q_status.full;
   assign accept    = push && !q_status.full;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign range_min = min_ff;
   assign range_max = max_ff;

   // mod 2^32 falls out of the truncation
   assign lcg_next = DATA_W'(lcg_ff * LCG_MUL + LCG_ADD);

   assign q_push  = accept && (req_kind == KIND_DRAW);
   assign q_wdata = lcg_next;

   always_comb begin
      lcg_in = lcg_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (accept) begin
         lcg_in = (req_kind == KIND_SEED) ? req_seed_value : lcg_next;
      end
      if (csr_wr) begin
         case (paddr[2])
            REG_RANGE_MIN: min_in = pwdata;
            REG_RANGE_MAX: max_in = pwdata;
            default:       min_in = min_ff;
         endcase
      end
      case (paddr[2])
         REG_RANGE_MIN: prdata = min_ff;
         REG_RANGE_MAX: prdata = max_ff;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff <= '0;
         min_ff <= RANGE_MIN_RST;
         max_ff <= RANGE_MAX_RST;
      end else begin
         lcg_ff <= lcg_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

endmodule

>>> hdl/lrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_back
// Maps queued states into the range with a bit-serial remainder unit and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module lrr_back
   import lrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // queue side
   input  q_status_type      q_status,
   input  logic [DATA_W-1:0] q_rdata,
   output logic              q_pop,
   // live range
   input  logic [DATA_W-1:0] range_min,
   input  logic [DATA_W-1:0] range_max,
   // result channel
   output logic              empty,
   input  logic              pop,
   output logic [DATA_W-1:0] rsp_value,
   output logic              rsp_range_error
);

   bk_state_type state_ff, state_in;

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    dvd_ff, dvd_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W:0]      span_ff, span_in;
   logic [DATA_W-1:0]    base_ff, base_in;
   logic                 err_ff, err_in;
   logic                 out_vld_ff, out_vld_in;
   logic [DATA_W-1:0]    out_val_ff, out_val_in;
   logic                 out_err_ff, out_err_in;

   logic [DATA_W:0]      diff;
   logic                 rng_bad;
   logic [DATA_W:0]      shifted;
   logic                 slot_free;

   assign diff    = {range_max[DATA_W-1], range_max} - {range_min[DATA_W-1], range_min};
   assign rng_bad = $signed(range_max) < $signed(range_min);
   assign shifted = {rem_ff, dvd_ff[DATA_W-1]};
   assign slot_free = !out_vld_ff || pop;

   assign empty           = !out_vld_ff;
   assign rsp_value       = out_val_ff;
   assign rsp_range_error = out_err_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      span_in    = span_ff;
      base_in    = base_ff;
      err_in     = err_ff;
      out_vld_in = out_vld_ff && !pop;
      out_val_in = out_val_ff;
      out_err_in = out_err_ff;
      q_pop      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop   = 1'b1;
               dvd_in  = q_rdata;
               rem_in  = '0;
               cnt_in  = '0;
               span_in = diff + 1'b1;
               base_in = range_min;
               err_in  = rng_bad;
               // empty range: remainder stays zero so value is range_min
               state_in = rng_bad ? BK_DONE : BK_DIV;
            end
         end
         BK_DIV: begin
            dvd_in = dvd_ff << 1;
            if (shifted >= span_ff) begin
               rem_in = DATA_W'(shifted - span_ff);
            end else begin
               rem_in = shifted[DATA_W-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (slot_free) begin
               out_vld_in = 1'b1;
               out_val_in = base_ff + rem_ff;
               out_err_in = err_ff;
               state_in   = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      span_ff    <= span_in;
      base_ff    <= base_in;
      err_ff     <= err_in;
      out_val_ff <= out_val_in;
      out_err_ff <= out_err_in;
   end

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> ({1'b0, rem_ff} < span_ff))
      else $error("partial remainder not below span");

   a_out_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> ($past(state_ff) == BK_DONE))
      else $error("result loaded outside done state");

   a_err_zero_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && err_ff) |-> (rem_ff == '0))
      else $error("empty range with nonzero offset");

endmodule

>>> test/lcg_ranged_random_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_ranged_random_top_tb
// Self-checking bench for the ranged LCG block. Seed and draw beats go in
// through push/full, the range is retuned over the APB port between phases,
// and every popped draw is checked against a generator model kept here.
// ----------------------------------------------------------------------------
module lcg_ranged_random_top_tb
   import lrr_pkg::*;
();

   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 40;   // covers the push-to-rsp latency of a draw
   localparam int HOLD_CYCLES  = 600;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASES       = 8;
   localparam int PHASE_BEATS  = 100;
   localparam int MAX_GAP      = 11;
   localparam int N_CORNERS    = 8;

   class lcg_draw_scoreboard;
      typedef struct packed {
         logic [DATA_W-1:0] value;
         logic              range_error;
      } draw_type;

      logic [DATA_W-1:0] gen_state;
      logic [DATA_W-1:0] lo_bound;
      logic [DATA_W-1:0] hi_bound;
      draw_type          pending_draws[$];
      int                n_errors;

      function new();
         gen_state = '0;
         lo_bound  = RANGE_MIN_RST;
         hi_bound  = RANGE_MAX_RST;
         n_errors  = 0;
      endfunction

      function void write_bound(logic idx, logic [DATA_W-1:0] v);
         if (idx == REG_RANGE_MIN) begin
            lo_bound = v;
         end else begin
            hi_bound = v;
         end
      endfunction

      // seed beats only reload the state; draws step it and map into range
      function void note_item(logic kind, logic [DATA_W-1:0] seed);
         longint   lo, hi, span;
         draw_type d;
         if (kind == KIND_SEED) begin
            gen_state = seed;
         end else begin
            gen_state = gen_state * LCG_MUL + LCG_ADD;
            lo = longint'($signed(lo_bound));
            hi = longint'($signed(hi_bound));
            if (hi < lo) begin
               d.value       = lo_bound;
               d.range_error = 1'b1;
            end else begin
               span          = hi - lo + 1;   // up to 2^32
               d.value       = lo_bound + DATA_W'(longint'(gen_state) % span);
               d.range_error = 1'b0;
            end
            pending_draws.push_back(d);
         end
      endfunction

      function void check_draw(logic [DATA_W-1:0] value, logic range_error);
         draw_type d;
         if (pending_draws.size() == 0) begin
            $error("unexpected draw: value %0d range_error %0b",
                   $signed(value), range_error);
            n_errors++;
         end else begin
            d = pending_draws.pop_front();
            if (value !== d.value) begin
               $error("value: expected %0d, got %0d", $signed(d.value), $signed(value));
               n_errors++;
            end
            if (range_error !== d.range_error) begin
               $error("range_error: expected %0b, got %0b", d.range_error, range_error);
               n_errors++;
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_kind;
   logic [DATA_W-1:0]     req_seed_value;
   logic                  empty;
   logic                  pop;
   logic [DATA_W-1:0]     rsp_value;
   logic                  rsp_range_error;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   lcg_draw_scoreboard draw_sb = new();
   bit                 tx_gaps;
   bit                 rx_gaps;

   // range corners: full span, widest empty, single values, negative,
   // off-by-one empty, signed wrap of 0..-1, span of 2^32 - 1
   logic [DATA_W-1:0] corner_min [N_CORNERS] = '{
      32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hFFFF_FC18, 32'd5, 32'd0, 32'h8000_0001};
   logic [DATA_W-1:0] corner_max [N_CORNERS] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
      32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFF, 32'h7FFF_FFFF};

   lcg_ranged_random_top DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_kind        (req_kind),
      .req_seed_value  (req_seed_value),
      .empty           (empty),
      .pop             (pop),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // push stays high across back-to-back beats; lowered only for a gap or in settle
   task automatic send_item(input logic kind, input logic [DATA_W-1:0] seed);
      int gap;
      gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push           <= 1'b1;
      req_kind       <= kind;
      req_seed_value <= seed;
      do @(posedge clock); while (full);
      draw_sb.note_item(kind, seed);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (draw_sb.pending_draws.size() != 0) @(posedge clock);
      // a trailing seed beat gives no rsp, so allow for it as well
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
      logic idx;
      psel   <= 1'b1;
      pwrite <= 1'b1;
      for (int r = 0; r < 2; r++) begin
         idx = (r == 0) ? REG_RANGE_MIN : REG_RANGE_MAX;
         paddr   <= {idx, 2'b00};
         pwdata  <= (r == 0) ? lo : hi;
         penable <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         draw_sb.write_bound(idx, (r == 0) ? lo : hi);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] seed;
      logic              kind;
      int                k;
      reset          = 1'b1;
      push           = 1'b0;
      req_kind       = KIND_DRAW;
      req_seed_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      tx_gaps        = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // draws from the reset state, then the seed extremes
      send_item(KIND_DRAW, '0);
      send_item(KIND_DRAW, {DATA_W{1'b1}});
      send_item(KIND_SEED, '0);
      send_item(KIND_DRAW, $urandom());
      send_item(KIND_SEED, {DATA_W{1'b1}});
      for (int i = 0; i < N_CORNERS; i++) begin
         settle();
         set_range(corner_min[i], corner_max[i]);
         send_item(KIND_SEED, $urandom());
         send_item(KIND_DRAW, $urandom());
         send_item(KIND_DRAW, $urandom());
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         lo = $urandom();
         hi = $urandom();
         case ($urandom_range(0, 3))
            0: hi = lo + $urandom_range(0, 300);
            1: hi = lo - $urandom_range(1, 100);
            2: ;
            default: begin
               k  = $urandom_range(0, N_CORNERS - 1);
               lo = corner_min[k];
               hi = corner_max[k];
            end
         endcase
         set_range(lo, hi);
         tx_gaps = ($urandom_range(0, 3) != 0);
         repeat (PHASE_BEATS) begin
            kind = ($urandom_range(0, 4) == 0) ? KIND_SEED : KIND_DRAW;
            seed = $urandom();
            if ($urandom_range(0, 15) == 0) begin
               seed = $urandom_range(0, 1) ? {DATA_W{1'b1}} : '0;
            end
            send_item(kind, seed);
         end
      end

      settle();
      if (draw_sb.n_errors == 0 && draw_sb.pending_draws.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // result side: random pop gaps, plus two long hold-offs to back up the block
   initial begin
      int gap;
      int n_popped;
      pop      = 1'b0;
      rx_gaps  = 1'b1;
      n_popped = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (n_popped % 64 == 0) begin
            rx_gaps = ($urandom_range(0, 2) != 0);
         end
         gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (n_popped == 150 || n_popped == 450) begin
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         draw_sb.check_draw(rsp_value, rsp_range_error);
         n_popped++;
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty) || psel) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
